// ===== sv/ttpt_pkg.sv =====
// Package: shared types and constants for the ternary tree prefix table.
package ttpt_pkg;

  localparam int unsigned NodeCountDef = 1024;
  localparam int unsigned KeyBytesDef  = 4;
  localparam int unsigned KeyFieldBytes = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] DIR_LO = 2'd0;
  localparam logic [1:0] DIR_EQ = 2'd1;
  localparam logic [1:0] DIR_HI = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ALLOC,
    S_LINK,
    S_DONE
  } state_t;

endpackage

// ===== sv/ternary_tree_prefix_table_top.sv =====
// Top level: ternary search tree prefix table with a single node memory.
//
// Input channel in_*: one request per transaction, insert (req_type 0) or
// longest prefix lookup (req_type 1). Result channel out_*: one result per
// request carrying status, match_length and match_value.
// One request is in work at a time. The node memory has one read port
// with a registered output; each tree node visited goes through a read
// state, then a compare state. An insert that appends new nodes writes
// them one per allocation step, then patches the parent link in a further
// step when the chain hangs off an existing node.
// The time to a result depends on the data; the next request is taken in
// the cycle after the result moves into the output register.
// The result sits in an output register until taken; while out_stall holds
// it there, one more request is accepted and worked, and that one waits in
// its last state with the input stalled until the register frees up.
// Reset clears the node count (empty tree) and the control state; node
// memory contents are not cleared and need no clearing pass, since only
// nodes below the count are ever read.
module ternary_tree_prefix_table_top #(
  parameter int unsigned NODE_COUNT = ttpt_pkg::NodeCountDef,
  parameter int unsigned KEY_BYTES  = ttpt_pkg::KeyBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_key_bytes,
  input  logic [2:0]  in_key_length,
  input  logic [15:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_match_length,
  output logic [15:0] out_match_value
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int IW = $clog2(KEY_BYTES + 1);

  typedef struct packed {
    logic [7:0]    kbyte;
    logic [15:0]   val;
    logic          valid;
    logic [AW-1:0] lo;
    logic [AW-1:0] eq;
    logic [AW-1:0] hi;
  } node_t;

  node_t mem [NODE_COUNT];
  node_t rd_r;

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  node_t           mem_wd;
  logic [AW-1:0]   mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  ttpt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          req_r, req_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [IW-1:0] len_r, len_nxt;
  logic [15:0]   val_r, val_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic          attach_r, attach_nxt;
  node_t         par_r, par_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [IW-1:0] need_r, need_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [2:0]    ml_r, ml_nxt;
  logic [15:0]   mv_r, mv_nxt;
  logic          res_vld_r, res_vld_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic [2:0]    res_ml_r, res_ml_nxt;
  logic [15:0]   res_mv_r, res_mv_nxt;

  function automatic logic [7:0] kb(input logic [31:0] k, input logic [IW-1:0] i);
    logic [7:0] r;
    r = 8'd0;
    for (int n = 0; n < ttpt_pkg::KeyFieldBytes; n++) begin
      if (32'(i) == n) r = k[31 - 8*n -: 8];
    end
    return r;
  endfunction

  logic [IW-1:0] in_len_sat;
  always_comb begin
    if (32'(in_key_length) > KEY_BYTES) in_len_sat = IW'(KEY_BYTES);
    else in_len_sat = IW'(in_key_length);
  end

  assign in_stall  = (state_r != ttpt_pkg::S_IDLE);
  assign out_valid = res_vld_r;
  assign out_status       = res_st_r;
  assign out_match_length = res_ml_r;
  assign out_match_value  = res_mv_r;

  logic [7:0]    b;
  logic [AW-1:0] link;
  logic          chld_ok;
  logic [CW-1:0] need_w;

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; req_nxt = req_r; key_nxt = key_r;
    len_nxt = len_r; val_nxt = val_r; cur_nxt = cur_r; idx_nxt = idx_r;
    dir_nxt = dir_r; attach_nxt = attach_r; par_nxt = par_r; first_nxt = first_r;
    need_nxt = need_r; j_nxt = j_r; st_nxt = st_r; ml_nxt = ml_r; mv_nxt = mv_r;
    res_vld_nxt = res_vld_r && out_stall;
    res_st_nxt = res_st_r; res_ml_nxt = res_ml_r; res_mv_nxt = res_mv_r;
    mem_we = 1'b0; mem_wa = cur_r; mem_wd = rd_r; mem_ra = cur_r;
    b = kb(key_r, idx_r);
    link = rd_r.lo;
    chld_ok = 1'b0;
    need_w = CW'(len_r) - CW'(idx_r);
    unique case (state_r)
      ttpt_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type; key_nxt = in_key_bytes; len_nxt = in_len_sat;
          val_nxt = in_entry_value; cur_nxt = '0; idx_nxt = '0;
          attach_nxt = 1'b0; st_nxt = ttpt_pkg::ST_OK; ml_nxt = '0; mv_nxt = '0;
          if (in_len_sat == '0) begin
            if (in_req_type == ttpt_pkg::REQ_INSERT) st_nxt = ttpt_pkg::ST_EMPTY;
            state_nxt = ttpt_pkg::S_DONE;
          end else if (used_r == '0) begin
            state_nxt = (in_req_type == ttpt_pkg::REQ_LOOKUP) ? ttpt_pkg::S_DONE
                                                              : ttpt_pkg::S_ALLOC;
            need_nxt = in_len_sat; first_nxt = '0; j_nxt = '0;
            if (in_req_type == ttpt_pkg::REQ_INSERT &&
                CW'(in_len_sat) > CW'(NODE_COUNT)) begin
              st_nxt = ttpt_pkg::ST_FULL; state_nxt = ttpt_pkg::S_DONE;
            end
          end else begin
            state_nxt = ttpt_pkg::S_READ;
          end
        end
      end
      ttpt_pkg::S_READ: begin
        mem_ra = cur_r;
        state_nxt = ttpt_pkg::S_EVAL;
      end
      ttpt_pkg::S_EVAL: begin
        priority if (b == rd_r.kbyte) begin
          dir_nxt = ttpt_pkg::DIR_EQ; link = rd_r.eq;
        end else if (b < rd_r.kbyte) begin
          dir_nxt = ttpt_pkg::DIR_LO; link = rd_r.lo;
        end else begin
          dir_nxt = ttpt_pkg::DIR_HI; link = rd_r.hi;
        end
        chld_ok = (link != '0) && (CW'(link) < used_r);
        par_nxt = rd_r;
        if (req_r == ttpt_pkg::REQ_LOOKUP) begin
          if (b == rd_r.kbyte) begin
            if (rd_r.valid) begin
              ml_nxt = 3'(idx_r) + 3'd1; mv_nxt = rd_r.val;
            end
            idx_nxt = idx_r + 1'b1;
            if (idx_r + 1'b1 >= len_r || !chld_ok) state_nxt = ttpt_pkg::S_DONE;
            else begin cur_nxt = link; state_nxt = ttpt_pkg::S_READ; end
          end else if (!chld_ok) state_nxt = ttpt_pkg::S_DONE;
          else begin cur_nxt = link; state_nxt = ttpt_pkg::S_READ; end
        end else begin
          if (b == rd_r.kbyte && idx_r + 1'b1 == len_r) begin
            mem_we = 1'b1; mem_wa = cur_r;
            mem_wd = rd_r; mem_wd.val = val_r; mem_wd.valid = 1'b1;
            state_nxt = ttpt_pkg::S_DONE;
          end else begin
            if (b == rd_r.kbyte) idx_nxt = idx_r + 1'b1;
            if (chld_ok) begin
              cur_nxt = link; state_nxt = ttpt_pkg::S_READ;
            end else begin
              attach_nxt = 1'b1;
              need_w = CW'(len_r) - CW'(idx_nxt);
              need_nxt = IW'(need_w); first_nxt = used_r; j_nxt = '0;
              if ({1'b0, used_r} + {1'b0, need_w} > (CW+1)'(NODE_COUNT)) begin
                st_nxt = ttpt_pkg::ST_FULL; state_nxt = ttpt_pkg::S_DONE;
              end else state_nxt = ttpt_pkg::S_ALLOC;
            end
          end
        end
      end
      ttpt_pkg::S_ALLOC: begin
        mem_we = 1'b1;
        mem_wa = AW'(first_r + CW'(j_r));
        mem_wd.kbyte = kb(key_r, idx_r + j_r);
        mem_wd.lo = '0; mem_wd.hi = '0;
        mem_wd.val = '0; mem_wd.valid = 1'b0;
        mem_wd.eq = AW'(first_r + CW'(j_r) + CW'(1));
        if (j_r + 1'b1 == need_r) begin
          mem_wd.eq = '0; mem_wd.val = val_r; mem_wd.valid = 1'b1;
          used_nxt = first_r + CW'(need_r);
          state_nxt = attach_r ? ttpt_pkg::S_LINK : ttpt_pkg::S_DONE;
        end
        j_nxt = j_r + 1'b1;
      end
      ttpt_pkg::S_LINK: begin
        mem_we = 1'b1; mem_wa = cur_r; mem_wd = par_r;
        unique case (dir_r)
          ttpt_pkg::DIR_LO: mem_wd.lo = AW'(first_r);
          ttpt_pkg::DIR_EQ: mem_wd.eq = AW'(first_r);
          default:          mem_wd.hi = AW'(first_r);
        endcase
        state_nxt = ttpt_pkg::S_DONE;
      end
      ttpt_pkg::S_DONE: begin
        // hand over to the output register once it is free or being taken
        if (!res_vld_r || !out_stall) begin
          res_vld_nxt = 1'b1;
          res_st_nxt = st_r; res_ml_nxt = ml_r; res_mv_nxt = mv_r;
          state_nxt = ttpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ttpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ttpt_pkg::S_IDLE;
      used_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      res_vld_r <= res_vld_nxt;
    end
    req_r <= req_nxt; key_r <= key_nxt; len_r <= len_nxt; val_r <= val_nxt;
    cur_r <= cur_nxt; idx_r <= idx_nxt; dir_r <= dir_nxt; attach_r <= attach_nxt;
    par_r <= par_nxt; first_r <= first_nxt; need_r <= need_nxt; j_r <= j_nxt;
    st_r <= st_nxt; ml_r <= ml_nxt; mv_r <= mv_nxt;
    res_st_r <= res_st_nxt; res_ml_r <= res_ml_nxt; res_mv_r <= res_mv_nxt;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ternary tree prefix table: random and directed requests checked by a predictor.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned NODES = 1024;
  localparam int unsigned MAX_KEY = 4;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key_bytes;
    logic [2:0]  key_length;
    logic [15:0] entry_value;
  } prefix_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  match_length;
    logic [15:0] match_value;
  } prefix_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [31:0] in_key_bytes = '0;
  logic [2:0] in_key_length = '0;
  logic [15:0] in_entry_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_match_length;
  logic [15:0] out_match_value;

  ternary_tree_prefix_table_top uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the node pool
  logic [7:0]  tree_byte [NODES];
  logic [15:0] tree_val [NODES];
  logic        tree_valid [NODES];
  int unsigned tree_link [NODES][3];
  int unsigned tree_used;

  prefix_req_t pending_reqs[$];
  prefix_rsp_t expected_rsps[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          stim_done = 1'b0;
  bit          hold_off = 1'b0;

  function automatic logic [7:0] byte_at(logic [31:0] key, int unsigned idx);
    if (idx >= 4) return 8'h00;
    return key[31 - 8 * idx -: 8];
  endfunction

  function automatic int unsigned child_of(int unsigned cur, int unsigned dir);
    int unsigned c;
    c = tree_link[cur][dir];
    if (c == 0 || c >= tree_used) return 0;
    return c;
  endfunction

  function automatic prefix_rsp_t predict_prefix(prefix_req_t r);
    prefix_rsp_t rsp;
    int unsigned len, cur, i, dir, nx, need, first;
    logic [7:0] b, nb;
    bit attach, done;
    rsp = '0;
    len = (r.key_length > MAX_KEY) ? MAX_KEY : r.key_length;
    cur = 0; i = 0; dir = 0; attach = 0; done = 0;
    if (r.req_type == ttpt_pkg::REQ_LOOKUP) begin
      if (tree_used != 0) begin
        while (i < len) begin
          b = byte_at(r.key_bytes, i);
          nb = tree_byte[cur];
          if (b == nb) begin
            if (tree_valid[cur]) begin
              rsp.match_length = 3'(i + 1);
              rsp.match_value = tree_val[cur];
            end
            i++;
            if (i >= len) break;
            nx = child_of(cur, ttpt_pkg::DIR_EQ);
          end else begin
            nx = child_of(cur, b < nb ? ttpt_pkg::DIR_LO : ttpt_pkg::DIR_HI);
          end
          if (nx == 0) break;
          cur = nx;
        end
      end
    end else if (len == 0) begin
      rsp.status = ttpt_pkg::ST_EMPTY;
    end else begin
      if (tree_used != 0) begin
        forever begin
          b = byte_at(r.key_bytes, i);
          nb = tree_byte[cur];
          if (b == nb) begin
            if (i + 1 == len) begin
              tree_val[cur] = r.entry_value;
              tree_valid[cur] = 1'b1;
              done = 1;
              break;
            end
            dir = ttpt_pkg::DIR_EQ;
          end else begin
            dir = (b < nb) ? ttpt_pkg::DIR_LO : ttpt_pkg::DIR_HI;
          end
          nx = child_of(cur, dir);
          if (dir == ttpt_pkg::DIR_EQ) i++;
          if (nx == 0) begin
            attach = 1;
            break;
          end
          cur = nx;
        end
      end
      if (!done) begin
        need = len - i;
        if (tree_used + need > NODES) begin
          rsp.status = ttpt_pkg::ST_FULL;
        end else begin
          first = tree_used;
          for (int unsigned j = 0; j < need; j++) begin
            tree_byte[first + j] = byte_at(r.key_bytes, i + j);
            tree_valid[first + j] = (j + 1 == need);
            tree_val[first + j] = (j + 1 == need) ? r.entry_value : 16'h0;
            tree_link[first + j][ttpt_pkg::DIR_LO] = 0;
            tree_link[first + j][ttpt_pkg::DIR_HI] = 0;
            tree_link[first + j][ttpt_pkg::DIR_EQ] = (j + 1 < need) ? first + j + 1 : 0;
          end
          if (attach) tree_link[cur][dir] = first;
          tree_used = first + need;
        end
      end
    end
    return rsp;
  endfunction

  // with narrow set, keys are drawn from a small byte alphabet so lookups and overwrites hit shared prefixes
  function automatic prefix_req_t make_req(bit lookup, bit narrow);
    prefix_req_t r;
    r.req_type = lookup ? ttpt_pkg::REQ_LOOKUP : ttpt_pkg::REQ_INSERT;
    r.key_bytes = $urandom;
    if (narrow) begin
      for (int k = 0; k < 4; k++) r.key_bytes[8 * k +: 8] = 8'(8'h40 + $urandom_range(0, 3));
    end
    r.key_length = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
    r.entry_value = 16'($urandom);
    return r;
  endfunction

  function automatic prefix_req_t mk(logic t, logic [31:0] k, logic [2:0] l, logic [15:0] v);
    prefix_req_t r;
    r.req_type = t; r.key_bytes = k; r.key_length = l; r.entry_value = v;
    return r;
  endfunction

  initial begin
    for (int n = 0; n < NODES; n++) begin
      tree_link[n][0] = 0; tree_link[n][1] = 0; tree_link[n][2] = 0;
      tree_byte[n] = '0; tree_val[n] = '0; tree_valid[n] = 1'b0;
    end
    tree_used = 0;
    // lookup on empty tree, empty insert, extremes, oversized length, overwrite, siblings
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0A80101, 3'd4, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hC0A80101, 3'd0, 16'h1234));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hC0A80000, 3'd2, 16'hFFFF));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hC0A80101, 3'd7, 16'h0001));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0A80101, 3'd4, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0A8FF01, 3'd4, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hC0A80000, 3'd2, 16'h0000));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0A80505, 3'd6, 16'hFFFF));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'h00000000, 3'd1, 16'hA5A5));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hFFFFFFFF, 3'd4, 16'h5A5A));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_INSERT, 32'hC0000000, 3'd1, 16'h00C0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'h00000000, 3'd4, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hFFFFFFFF, 3'd3, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0123456, 3'd4, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'hC0A80101, 3'd0, 16'h0));
    pending_reqs.push_back(mk(ttpt_pkg::REQ_LOOKUP, 32'h7F000001, 3'd4, 16'h0));
    for (int n = 0; n < 700; n++) pending_reqs.push_back(make_req($urandom_range(0, 1), 1));
    // fill the pool with wide keys to reach pool-full, then keep probing
    for (int n = 0; n < 300; n++)
      pending_reqs.push_back(make_req($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
    for (int n = 0; n < 40; n++) pending_reqs.push_back(make_req($urandom_range(0, 1), 1));
  end

  // driver: bursts and gaps, pauses once for a full drain
  int unsigned burst_left = 0, gap_left = 0, sent_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(predict_prefix(prefix_req_t'({in_req_type, in_key_bytes,
                                                              in_key_length, in_entry_value})));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (sent_count == 400 && !hold_off && in_valid && !in_stall) begin
          hold_off <= 1'b1;
          in_valid <= 1'b0;
        end else if (hold_off && expected_rsps.size() != 0 && sent_count >= 400
                     && sent_count < 402) begin
          in_valid <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
          {in_req_type, in_key_bytes, in_key_length, in_entry_value} <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      out_stall <= (stall_phase % 1000 < 300) ? 1'b0 : ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transaction status=%0d len=%0d val=%h", $time,
                   out_status, out_match_length, out_match_value);
          fail_count <= fail_count + 1;
        end else begin
          prefix_rsp_t want;
          want = expected_rsps.pop_front();
          if (want.status !== out_status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            fail_count <= fail_count + 1;
          end
          if (want.match_length !== out_match_length) begin
            $display("%0t: match_length expected %0d actual %0d", $time,
                     want.match_length, out_match_length);
            fail_count <= fail_count + 1;
          end
          if (want.match_value !== out_match_value) begin
            $display("%0t: match_value expected %h actual %h", $time,
                     want.match_value, out_match_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_rsps.size() == 0) && cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ternary_tree_prefix_table_top: mismatch");
    end else begin
      repeat (50) @(posedge clk);
      if (fail_count == 0) begin
        $display("ternary_tree_prefix_table_top: match");
      end else begin
        $display("ternary_tree_prefix_table_top: mismatch");
      end
    end
    $finish;
  end

endmodule
